// ----- hw/rtl/lobm_pkg.sv -----
// Package with the shared types and codes of the limit order book matcher.
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;

  localparam int unsigned PRICE_W = 17;
  localparam int unsigned QTY_W   = 16;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned TOTAL_W = 21;

  localparam logic [PRICE_W-1:0] EMPTY_ASK_RESET = 17'd99999;
  localparam logic [PRICE_W-1:0] EMPTY_BID_RESET = 17'd0;

  typedef enum logic [1:0] {
    ACT_BUY    = 2'd0,
    ACT_SELL   = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic {
    CFG_EMPTY_ASK = 1'b0,
    CFG_EMPTY_BID = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_TRADE = 1'b0,
    KIND_QUOTE = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSCAN,
    ST_MDEC,
    ST_CSCAN,
    ST_REST,
    ST_QSCAN,
    ST_QUOTE
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [QTY_W-1:0]   quantity;
    logic [PRICE_W-1:0] limit_price;
    logic [SEQ_W-1:0]   cancel_ref;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [QTY_W-1:0]   trade_size;
    logic [PRICE_W-1:0] trade_price;
    logic [TOTAL_W-1:0] bid_size;
    logic [PRICE_W-1:0] bid_price;
    logic [TOTAL_W-1:0] ask_size;
    logic [PRICE_W-1:0] ask_price;
    logic               dropped;
    logic               last;
  } out_t;

  // One resting order as held in the book memory.
  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   size;
    logic [SEQ_W-1:0]   seq;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ----- hw/rtl/lobm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lobm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/limit_order_book_matcher.sv -----
// Limit order book matcher with price-time priority, built around one book memory.
//
// Input beats (buy, sell, cancel, clear) arrive on in_valid_i/in_ready_o; every
// beat produces zero or more trade beats followed by one quote beat with last
// set, on out_valid_o/out_ready_i. Configuration writes are registered at once and
// never wait. Each item is handled on its own. A buy or a sell needs one match
// sweep of the book memory plus one decision step per fill, and one more such
// pass when the order is not used up. It then rests its remainder and sweeps
// once more for the quote; a cancel sweeps for its reference and then for the
// quote, and a clear sweeps only for the quote. Each sweep reads the book memory
// through its single read port, one entry per cycle. A finished result sits in
// the output register while the next step proceeds; the sequencer only waits
// when a new beat must be loaded and the receiver has not taken the previous one.
// Reset empties the book (valid flags cleared), sets the sequence count to one
// and restores the empty-side prices; the memory contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_matcher #(
  parameter int unsigned MAX_ORDERS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire lobm_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output lobm_pkg::out_t                     out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [lobm_pkg::PRICE_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_ORDERS);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(MAX_ORDERS);

  lobm_pkg::state_e state_q, state_d;

  logic [lobm_pkg::PRICE_W-1:0] empty_ask_q, empty_bid_q;
  logic [MAX_ORDERS-1:0]        valid_q;
  logic [lobm_pkg::SEQ_W-1:0]   seq_cnt_q;

  logic [1:0]                   act_q;
  logic [lobm_pkg::QTY_W-1:0]   rem_q;
  logic [lobm_pkg::PRICE_W-1:0] limit_q;
  logic [lobm_pkg::SEQ_W-1:0]   ref_q;
  logic [lobm_pkg::SEQ_W-1:0]   my_seq_q;
  logic                         dropped_q;

  // Sweep counter and read pipeline.
  logic [CW-1:0] cnt_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic          sweep_done;

  // Best resting entry found by the match sweep.
  logic                  best_found_q;
  logic [AW-1:0]         best_idx_q;
  lobm_pkg::entry_t      best_q;

  // Quote accumulators.
  logic                         bid_found_q, ask_found_q;
  logic [lobm_pkg::PRICE_W-1:0] bid_price_q, ask_price_q;
  logic [lobm_pkg::TOTAL_W-1:0] bid_total_q, ask_total_q;

  logic           out_valid_q;
  lobm_pkg::out_t out_q;
  logic           out_free;
  logic           out_load;
  lobm_pkg::out_t trade_beat;
  lobm_pkg::out_t quote_beat;

  // Memory ports.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  lobm_pkg::entry_t ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [lobm_pkg::ENTRY_W-1:0] ram_rdata;
  lobm_pkg::entry_t rd_entry;

  logic                  free_found;
  logic [AW-1:0]         free_idx;
  logic                  crossed;
  logic                  fill_partial;
  logic                  fill_go;
  logic [lobm_pkg::QTY_W-1:0] fill_size;
  logic                  other_side;
  logic                  rd_live;

  lobm_ram #(
    .WIDTH(lobm_pkg::ENTRY_W),
    .DEPTH(MAX_ORDERS)
  ) u_book (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry   = lobm_pkg::entry_t'(ram_rdata);
  assign rd_live    = rd_vld_q && valid_q[rd_idx_q];
  assign sweep_done = (cnt_q == LAST_CNT) && !rd_vld_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign other_side = ~act_q[0];
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign crossed = (act_q == lobm_pkg::ACT_BUY) ? (best_q.price > limit_q)
                                                : (best_q.price < limit_q);
  assign fill_partial = rem_q < best_q.size;
  assign fill_size    = fill_partial ? rem_q : best_q.size;
  assign fill_go      = best_found_q && !crossed && (rem_q != '0) && out_free;
  assign out_load     = ((state_q == lobm_pkg::ST_MDEC) && fill_go)
                        || ((state_q == lobm_pkg::ST_QUOTE) && out_free);

  // Lowest free entry for a resting remainder.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = MAX_ORDERS - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_found = 1'b1;
        free_idx   = AW'(k);
      end
    end
  end

  // Result beats as they would be loaded into the output register.
  always_comb begin
    trade_beat             = '0;
    trade_beat.kind        = lobm_pkg::KIND_TRADE;
    trade_beat.trade_size  = fill_size;
    trade_beat.trade_price = best_q.price;
    quote_beat             = '0;
    quote_beat.kind        = lobm_pkg::KIND_QUOTE;
    quote_beat.bid_size    = bid_found_q ? bid_total_q : '0;
    quote_beat.bid_price   = bid_found_q ? bid_price_q : empty_bid_q;
    quote_beat.ask_size    = ask_found_q ? ask_total_q : '0;
    quote_beat.ask_price   = ask_found_q ? ask_price_q : empty_ask_q;
    quote_beat.dropped     = dropped_q;
    quote_beat.last        = 1'b1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lobm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.action)
            lobm_pkg::ACT_BUY, lobm_pkg::ACT_SELL: state_d = lobm_pkg::ST_MSCAN;
            lobm_pkg::ACT_CANCEL:                  state_d = lobm_pkg::ST_CSCAN;
            default:                               state_d = lobm_pkg::ST_QSCAN;
          endcase
        end
      end
      lobm_pkg::ST_MSCAN: if (sweep_done) state_d = lobm_pkg::ST_MDEC;
      lobm_pkg::ST_MDEC: begin
        if (!best_found_q || crossed || rem_q == '0) begin
          state_d = lobm_pkg::ST_REST;
        end else if (out_free) begin
          state_d = fill_partial || (rem_q == best_q.size) ? lobm_pkg::ST_REST
                                                            : lobm_pkg::ST_MSCAN;
        end
      end
      lobm_pkg::ST_CSCAN: if (sweep_done) state_d = lobm_pkg::ST_QSCAN;
      lobm_pkg::ST_REST:  state_d = lobm_pkg::ST_QSCAN;
      lobm_pkg::ST_QSCAN: if (sweep_done) state_d = lobm_pkg::ST_QUOTE;
      lobm_pkg::ST_QUOTE: if (out_free) state_d = lobm_pkg::ST_IDLE;
      default:            state_d = lobm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory ports.
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = best_idx_q;
    ram_wdata  = best_q;
    ram_raddr  = cnt_q[AW-1:0];
    case (state_q)
      lobm_pkg::ST_IDLE: in_ready_o = 1'b1;
      lobm_pkg::ST_MDEC: begin
        ram_wdata.size = best_q.size - rem_q;
        ram_we = fill_go && fill_partial;
      end
      lobm_pkg::ST_REST: begin
        ram_waddr       = free_idx;
        ram_wdata.side  = act_q[0];
        ram_wdata.price = limit_q;
        ram_wdata.size  = rem_q;
        ram_wdata.seq   = my_seq_q;
        ram_we          = rem_q != '0 && free_found;
      end
      default: ;
    endcase
  end

  // Datapath and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lobm_pkg::ST_IDLE;
      empty_ask_q  <= lobm_pkg::EMPTY_ASK_RESET;
      empty_bid_q  <= lobm_pkg::EMPTY_BID_RESET;
      valid_q      <= '0;
      seq_cnt_q    <= lobm_pkg::SEQ_W'(1);
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        if (cfg_idx_i == lobm_pkg::CFG_EMPTY_ASK) empty_ask_q <= cfg_data_i;
        else                                      empty_bid_q <= cfg_data_i;
      end

      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      // The sweep issues one read per cycle; the counter restarts on entry.
      if (state_d != state_q) begin
        cnt_q    <= '0;
        rd_vld_q <= 1'b0;
      end else if (cnt_q != LAST_CNT) begin
        cnt_q    <= cnt_q + CW'(1);
        rd_vld_q <= 1'b1;
        rd_idx_q <= cnt_q[AW-1:0];
      end else begin
        rd_vld_q <= 1'b0;
      end

      case (state_q)
        lobm_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            act_q     <= in_data_i.action;
            rem_q     <= in_data_i.quantity;
            limit_q   <= in_data_i.limit_price;
            ref_q     <= in_data_i.cancel_ref;
            my_seq_q  <= seq_cnt_q;
            dropped_q <= 1'b0;
            best_found_q <= 1'b0;
            bid_found_q  <= 1'b0;
            ask_found_q  <= 1'b0;
            if (in_data_i.action == lobm_pkg::ACT_CLEAR) begin
              valid_q   <= '0;
              seq_cnt_q <= lobm_pkg::SEQ_W'(1);
            end else begin
              seq_cnt_q <= seq_cnt_q + lobm_pkg::SEQ_W'(1);
            end
          end
        end
        lobm_pkg::ST_MSCAN: begin
          if (rd_live && rd_entry.side == other_side) begin
            if (!best_found_q
                || (rd_entry.price != best_q.price
                    && (other_side ? rd_entry.price < best_q.price
                                   : rd_entry.price > best_q.price))
                || (rd_entry.price == best_q.price && rd_entry.seq < best_q.seq)) begin
              best_found_q <= 1'b1;
              best_idx_q   <= rd_idx_q;
              best_q       <= rd_entry;
            end
          end
        end
        lobm_pkg::ST_MDEC: begin
          // The candidate is kept only while a fill waits for the output register.
          best_found_q <= best_found_q && !crossed && (rem_q != '0) && !out_free;
          if (fill_go) begin
            rem_q <= rem_q - fill_size;
            if (!fill_partial) valid_q[best_idx_q] <= 1'b0;
            out_q <= trade_beat;
          end
        end
        lobm_pkg::ST_CSCAN: begin
          if (rd_live && rd_entry.seq == ref_q) valid_q[rd_idx_q] <= 1'b0;
        end
        lobm_pkg::ST_REST: begin
          if (rem_q != '0) begin
            if (free_found) valid_q[free_idx] <= 1'b1;
            else            dropped_q <= 1'b1;
          end
        end
        lobm_pkg::ST_QSCAN: begin
          if (rd_live && rd_entry.side == 1'b0) begin
            if (!bid_found_q || rd_entry.price > bid_price_q) begin
              bid_found_q <= 1'b1;
              bid_price_q <= rd_entry.price;
              bid_total_q <= lobm_pkg::TOTAL_W'(rd_entry.size);
            end else if (rd_entry.price == bid_price_q) begin
              bid_total_q <= bid_total_q + lobm_pkg::TOTAL_W'(rd_entry.size);
            end
          end
          if (rd_live && rd_entry.side == 1'b1) begin
            if (!ask_found_q || rd_entry.price < ask_price_q) begin
              ask_found_q <= 1'b1;
              ask_price_q <= rd_entry.price;
              ask_total_q <= lobm_pkg::TOTAL_W'(rd_entry.size);
            end else if (rd_entry.price == ask_price_q) begin
              ask_total_q <= ask_total_q + lobm_pkg::TOTAL_W'(rd_entry.size);
            end
          end
        end
        lobm_pkg::ST_QUOTE: begin
          if (out_free) out_q <= quote_beat;
        end
        default: ;
      endcase
    end
  end

  // A beat accepted from the input keeps the sequencer busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer took a beat but stayed idle");

  // Only quotes close an item, and trades never carry a drop flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == lobm_pkg::KIND_TRADE |->
      !out_data_o.last && !out_data_o.dropped)
    else $error("trade beat marked as last or dropped");

  // The book memory is written only in the fill or the rest step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == lobm_pkg::ST_MDEC || state_q == lobm_pkg::ST_REST)
    else $error("book memory written outside the fill or rest step");

  // Returning to idle follows the loading of the closing quote.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == lobm_pkg::ST_QUOTE) && state_q == lobm_pkg::ST_IDLE |->
      out_valid_o && out_data_o.last)
    else $error("item closed without a quote");

endmodule
`default_nettype wire
